// ===== hdl/lzhcmf_pkg.sv =====
// Shared types, constants and helpers of the LZ77 hash-chain match finder.
`default_nettype none
package lzhcmf_pkg;

   localparam int WINDOW_BITS_DEF     = 16;
   localparam int HASH_TABLE_BITS_DEF = 16;
   localparam int BUFFER_BITS_DEF     = 17;

   localparam int POS_W   = 32;
   localparam int LEN_W   = 9;
   localparam int DIST_W  = 17;
   localparam int LEVEL_W = 4;
   localparam int CHAIN_W = 10;

   localparam logic [31:0]        HASH_MUL    = 32'd2654435761;
   localparam logic [LEN_W-1:0]   MIN_LEN     = 9'd4;
   localparam logic [LEN_W-1:0]   MAX_LEN     = 9'd258;
   localparam logic [POS_W-1:0]   LOOKAHEAD   = 32'd259;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd6;
   localparam logic [CHAIN_W-1:0] CHAIN_FAST  = 10'd32;
   localparam logic [CHAIN_W-1:0] CHAIN_MID   = 10'd128;
   localparam logic [CHAIN_W-1:0] CHAIN_MAX   = 10'd512;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_EVAL,
      OP_DEC_INIT,
      OP_INS_SKIP,
      OP_INS_BEGIN,
      OP_HASH_STEP,
      OP_HASH_MUL,
      OP_HEAD_RD,
      OP_INSERT,
      OP_FIND_INIT,
      OP_LOAD_HEAD,
      OP_TAKE_CAND,
      OP_PRE_RD,
      OP_CMP_RD,
      OP_L_INC,
      OP_CMP_END,
      OP_LINK_RD,
      OP_LOAD_LINK,
      OP_FIND_DONE,
      OP_LAZY_BEGIN,
      OP_LAZY_KEEP,
      OP_TOK_MATCH,
      OP_LIT_RD,
      OP_TOK_LIT,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_WRITE,
      EV_DECIDE,
      EV_END,
      EV_OVF
   } ev_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      ev_type ev;
      logic   clear_last;
      logic   check_go;
      logic   pend_zero;
      logic   sync_done;
      logic   ins_skip;
      logic   hash_last;
      logic   find_skip;
      logic   link_stop;
      logic   best_zero;
      logic   bytes_eq;
      logic   l_at_max;
      logic   l_gt_best;
      logic   phase;
      logic   lazy_go;
      logic   dec_len_zero;
      logic   m2_better;
      logic   out_free;
   } dp_status_type;

   function automatic logic [CHAIN_W-1:0] chain_limit(input logic [LEVEL_W-1:0] lv);
      logic [CHAIN_W-1:0] lim;
      if (lv inside {[0:1]}) begin
         lim = CHAIN_FAST;
      end else if (lv inside {[2:6]}) begin
         lim = CHAIN_MID;
      end else begin
         lim = CHAIN_MAX;
      end
      return lim;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/lzhcmf_ctrl.sv =====
// Sequencer that steps the match finder datapath through accept, insert, search and emit.
`default_nettype none
module lzhcmf_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire lzhcmf_pkg::dp_status_type status,
   output lzhcmf_pkg::dp_cmd_type        cmd
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_CHECK,
      S_DEC_INIT,
      S_SYNC,
      S_HASH,
      S_HMUL,
      S_HEAD_RD,
      S_INSERT,
      S_FIND_INIT,
      S_FIND_HEAD,
      S_LINK,
      S_PRE_ADDR,
      S_PRE_DATA,
      S_CMP_ADDR,
      S_CMP_DATA,
      S_CMP_END,
      S_NEXT,
      S_NEXT_WAIT,
      S_FIND_DONE,
      S_AFTER1,
      S_AFTER2,
      S_LIT_RD,
      S_LIT_DATA,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ret_find_ff, ret_find_in;

   always_comb begin
      state_in    = state_ff;
      ret_find_in = ret_find_ff;
      cmd.op      = lzhcmf_pkg::OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = lzhcmf_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = lzhcmf_pkg::OP_ACCEPT;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.op = lzhcmf_pkg::OP_EVAL;
            case (status.ev)
               lzhcmf_pkg::EV_WRITE:  state_in = S_CHECK;
               lzhcmf_pkg::EV_DECIDE: state_in = S_DEC_INIT;
               lzhcmf_pkg::EV_END:    state_in = S_EMIT;
               lzhcmf_pkg::EV_OVF:    state_in = S_EMIT;
               default:               state_in = S_IDLE;
            endcase
         end
         S_CHECK: begin
            state_in = status.check_go ? S_DEC_INIT : S_IDLE;
         end
         S_DEC_INIT: begin
            cmd.op   = lzhcmf_pkg::OP_DEC_INIT;
            state_in = status.pend_zero ? S_SYNC : S_AFTER1;
         end
         S_SYNC: begin
            if (status.sync_done) begin
               state_in = S_FIND_INIT;
            end else if (status.ins_skip) begin
               cmd.op = lzhcmf_pkg::OP_INS_SKIP;
            end else begin
               cmd.op      = lzhcmf_pkg::OP_INS_BEGIN;
               ret_find_in = 1'b0;
               state_in    = S_HASH;
            end
         end
         S_HASH: begin
            cmd.op = lzhcmf_pkg::OP_HASH_STEP;
            if (status.hash_last) state_in = S_HMUL;
         end
         S_HMUL: begin
            cmd.op   = lzhcmf_pkg::OP_HASH_MUL;
            state_in = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            cmd.op   = lzhcmf_pkg::OP_HEAD_RD;
            state_in = ret_find_ff ? S_FIND_HEAD : S_INSERT;
         end
         S_INSERT: begin
            cmd.op   = lzhcmf_pkg::OP_INSERT;
            state_in = S_SYNC;
         end
         S_FIND_INIT: begin
            cmd.op      = lzhcmf_pkg::OP_FIND_INIT;
            ret_find_in = 1'b1;
            state_in    = status.find_skip ? S_FIND_DONE : S_HASH;
         end
         S_FIND_HEAD: begin
            cmd.op   = lzhcmf_pkg::OP_LOAD_HEAD;
            state_in = S_LINK;
         end
         S_LINK: begin
            if (status.link_stop) begin
               state_in = S_FIND_DONE;
            end else begin
               cmd.op   = lzhcmf_pkg::OP_TAKE_CAND;
               state_in = status.best_zero ? S_CMP_ADDR : S_PRE_ADDR;
            end
         end
         S_PRE_ADDR: begin
            cmd.op   = lzhcmf_pkg::OP_PRE_RD;
            state_in = S_PRE_DATA;
         end
         S_PRE_DATA: begin
            state_in = status.bytes_eq ? S_CMP_ADDR : S_NEXT;
         end
         S_CMP_ADDR: begin
            if (status.l_at_max) begin
               state_in = S_CMP_END;
            end else begin
               cmd.op   = lzhcmf_pkg::OP_CMP_RD;
               state_in = S_CMP_DATA;
            end
         end
         S_CMP_DATA: begin
            if (status.bytes_eq) begin
               cmd.op   = lzhcmf_pkg::OP_L_INC;
               state_in = S_CMP_ADDR;
            end else begin
               state_in = S_CMP_END;
            end
         end
         S_CMP_END: begin
            cmd.op   = lzhcmf_pkg::OP_CMP_END;
            state_in = (status.l_gt_best && status.l_at_max) ? S_FIND_DONE : S_NEXT;
         end
         S_NEXT: begin
            cmd.op   = lzhcmf_pkg::OP_LINK_RD;
            state_in = S_NEXT_WAIT;
         end
         S_NEXT_WAIT: begin
            cmd.op   = lzhcmf_pkg::OP_LOAD_LINK;
            state_in = S_LINK;
         end
         S_FIND_DONE: begin
            cmd.op   = lzhcmf_pkg::OP_FIND_DONE;
            state_in = status.phase ? S_AFTER2 : S_AFTER1;
         end
         S_AFTER1: begin
            if (status.lazy_go) begin
               cmd.op   = lzhcmf_pkg::OP_LAZY_BEGIN;
               state_in = S_SYNC;
            end else if (!status.dec_len_zero) begin
               cmd.op   = lzhcmf_pkg::OP_TOK_MATCH;
               state_in = S_EMIT;
            end else begin
               state_in = S_LIT_RD;
            end
         end
         S_AFTER2: begin
            if (status.m2_better) begin
               cmd.op   = lzhcmf_pkg::OP_LAZY_KEEP;
               state_in = S_LIT_RD;
            end else begin
               cmd.op   = lzhcmf_pkg::OP_TOK_MATCH;
               state_in = S_EMIT;
            end
         end
         S_LIT_RD: begin
            cmd.op   = lzhcmf_pkg::OP_LIT_RD;
            state_in = S_LIT_DATA;
         end
         S_LIT_DATA: begin
            cmd.op   = lzhcmf_pkg::OP_TOK_LIT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = lzhcmf_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         ret_find_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_find_ff <= ret_find_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/lzhcmf_dp.sv =====
// Datapath of the match finder: history, hash head and chain memories, search registers, output.
`default_nettype none
module lzhcmf_dp #(
   parameter int WINDOW_BITS     = lzhcmf_pkg::WINDOW_BITS_DEF,
   parameter int HASH_TABLE_BITS = lzhcmf_pkg::HASH_TABLE_BITS_DEF,
   parameter int BUFFER_BITS     = lzhcmf_pkg::BUFFER_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [lzhcmf_pkg::LEVEL_W-1:0]      csr_write_data,
   input  wire logic                                req_op,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_last,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic                                     rsp_is_match,
   output logic [7:0]                               rsp_literal,
   output logic [lzhcmf_pkg::LEN_W-1:0]             rsp_match_length,
   output logic [lzhcmf_pkg::DIST_W-1:0]            rsp_match_distance,
   output logic                                     rsp_stream_end,
   output logic                                     rsp_overflow,
   input  wire lzhcmf_pkg::dp_cmd_type              cmd,
   output lzhcmf_pkg::dp_status_type                status
);

   localparam int PW = lzhcmf_pkg::POS_W;
   localparam int LW = lzhcmf_pkg::LEN_W;
   localparam int DW = lzhcmf_pkg::DIST_W;
   localparam int CW = lzhcmf_pkg::CHAIN_W;
   localparam logic [PW:0] WIN_SIZE = (PW+1)'(1) << WINDOW_BITS;

   logic [7:0]  hist_mem  [2**BUFFER_BITS];
   logic [PW-1:0] heads_mem [2**HASH_TABLE_BITS];
   logic [PW-1:0] chain_mem [2**WINDOW_BITS];

   logic                       hist_we;
   logic [BUFFER_BITS-1:0]     hist_wa, hist_ra, hist_rb;
   logic [7:0]                 hist_rda_ff, hist_rdb_ff;
   logic                       heads_we;
   logic [HASH_TABLE_BITS-1:0] heads_wa, heads_ra;
   logic [PW-1:0]              heads_wd, heads_rd_ff;
   logic                       chain_we;
   logic [PW-1:0]              chain_rd_ff;

   logic [lzhcmf_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic          in_op_ff, in_op_in, in_last_ff, in_last_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic [PW-1:0] recv_ff, recv_in, cursor_ff, cursor_in, inserted_ff, inserted_in;
   logic [LW-1:0] pend_len_ff, pend_len_in;
   logic [DW-1:0] pend_dist_ff, pend_dist_in;
   logic          end_seen_ff, end_seen_in, rejected_ff, rejected_in;
   logic [HASH_TABLE_BITS-1:0] clr_ff, clr_in, hidx_ff, hidx_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          phase_ff, phase_in, lazy_ff, lazy_in;
   logic [CW-1:0] chain_lim_ff, chain_lim_in, chain_ff, chain_in;
   logic [LW-1:0] dec_len_ff, dec_len_in, m2_ff, m2_in;
   logic [DW-1:0] dec_dist_ff, dec_dist_in, d2_ff, d2_in;
   logic [PW-1:0] hbase_ff, hbase_in, hval_ff, hval_in, hprod_ff, hprod_in;
   logic [2:0]    hcnt_ff, hcnt_in;
   logic [PW-1:0] p_ff, p_in, link_ff, link_in, cand_ff, cand_in;
   logic [LW-1:0] maxlen_ff, maxlen_in, best_ff, best_in, l_ff, l_in;
   logic [DW-1:0] bdist_ff, bdist_in;
   logic          tok_match_ff, tok_match_in, tok_end_ff, tok_end_in, tok_ovf_ff, tok_ovf_in;
   logic [7:0]    tok_lit_ff, tok_lit_in;
   logic [LW-1:0] tok_len_ff, tok_len_in;
   logic [DW-1:0] tok_dist_ff, tok_dist_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_match_ff, rsp_match_in;
   logic          rsp_end_ff, rsp_end_in, rsp_ovf_ff, rsp_ovf_in;
   logic [7:0]    rsp_lit_ff, rsp_lit_in;
   logic [LW-1:0] rsp_len_ff, rsp_len_in;
   logic [DW-1:0] rsp_dist_ff, rsp_dist_in;

   logic [PW-1:0] tgt, cand_c, rem, find_res_dist;
   logic [LW-1:0] find_res;
   lzhcmf_pkg::ev_type ev;

   always_comb begin
      tgt    = pos_ff + PW'(phase_ff);
      cand_c = link_ff - PW'(1);
      rem    = recv_ff - tgt;
      if (rejected_ff) begin
         ev = lzhcmf_pkg::EV_OVF;
      end else if (!in_op_ff) begin
         if (end_seen_ff) begin
            ev = lzhcmf_pkg::EV_NONE;
         end else if (recv_ff[PW-1]) begin
            ev = lzhcmf_pkg::EV_OVF;
         end else begin
            ev = lzhcmf_pkg::EV_WRITE;
         end
      end else if (!end_seen_ff) begin
         ev = lzhcmf_pkg::EV_NONE;
      end else if (cursor_ff < recv_ff) begin
         ev = lzhcmf_pkg::EV_DECIDE;
      end else begin
         ev = lzhcmf_pkg::EV_END;
      end
      find_res      = (best_ff >= lzhcmf_pkg::MIN_LEN) ? best_ff : '0;
      find_res_dist = p_ff - cand_ff;
   end

   always_comb begin
      status.ev           = ev;
      status.clear_last   = &clr_ff;
      status.check_go     = (cursor_ff < recv_ff)
                            && (end_seen_ff || (recv_ff - cursor_ff) >= lzhcmf_pkg::LOOKAHEAD);
      status.pend_zero    = (pend_len_ff == '0);
      status.sync_done    = !(inserted_ff < tgt);
      status.ins_skip     = end_seen_ff
                            && (({1'b0, inserted_ff} + (PW+1)'(4)) > {1'b0, recv_ff});
      status.hash_last    = (hcnt_ff == 3'd4);
      status.find_skip    = end_seen_ff && (({1'b0, tgt} + (PW+1)'(4)) > {1'b0, recv_ff});
      status.link_stop    = (link_ff == '0) || (chain_ff == '0) || (cand_c >= p_ff)
                            || ({1'b0, p_ff - cand_c} > WIN_SIZE);
      status.best_zero    = (best_ff == '0);
      status.bytes_eq     = (hist_rda_ff == hist_rdb_ff);
      status.l_at_max     = (l_ff >= maxlen_ff);
      status.l_gt_best    = (l_ff > best_ff);
      status.phase        = phase_ff;
      status.lazy_go      = lazy_ff && (dec_len_ff != '0)
                            && (!end_seen_ff || ((pos_ff + PW'(1)) < recv_ff));
      status.dec_len_zero = (dec_len_ff == '0);
      status.m2_better    = (m2_ff > dec_len_ff);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // Memory addressing.
   always_comb begin
      hist_we  = (cmd.op == lzhcmf_pkg::OP_EVAL) && (ev == lzhcmf_pkg::EV_WRITE);
      hist_wa  = recv_ff[BUFFER_BITS-1:0];
      hist_ra  = hbase_ff[BUFFER_BITS-1:0];
      hist_rb  = p_ff[BUFFER_BITS-1:0];
      case (cmd.op)
         lzhcmf_pkg::OP_HASH_STEP: begin
            hist_ra = BUFFER_BITS'(hbase_ff + PW'(hcnt_ff));
         end
         lzhcmf_pkg::OP_PRE_RD: begin
            hist_ra = BUFFER_BITS'(cand_ff + PW'(best_ff));
            hist_rb = BUFFER_BITS'(p_ff + PW'(best_ff));
         end
         lzhcmf_pkg::OP_CMP_RD: begin
            hist_ra = BUFFER_BITS'(cand_ff + PW'(l_ff));
            hist_rb = BUFFER_BITS'(p_ff + PW'(l_ff));
         end
         lzhcmf_pkg::OP_LIT_RD: begin
            hist_ra = pos_ff[BUFFER_BITS-1:0];
         end
         default: begin
         end
      endcase
      heads_we = (cmd.op == lzhcmf_pkg::OP_CLEAR) || (cmd.op == lzhcmf_pkg::OP_INSERT);
      heads_wa = (cmd.op == lzhcmf_pkg::OP_CLEAR) ? clr_ff : hidx_ff;
      heads_wd = (cmd.op == lzhcmf_pkg::OP_CLEAR) ? '0 : inserted_ff + PW'(1);
      heads_ra = hprod_ff[PW-1 -: HASH_TABLE_BITS];
      chain_we = (cmd.op == lzhcmf_pkg::OP_INSERT);
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= in_byte_ff;
      end
      hist_rda_ff <= hist_mem[hist_ra];
      hist_rdb_ff <= hist_mem[hist_rb];
   end

   always_ff @(posedge clock) begin
      if (heads_we) begin
         heads_mem[heads_wa] <= heads_wd;
      end
      heads_rd_ff <= heads_mem[heads_ra];
   end

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[inserted_ff[WINDOW_BITS-1:0]] <= heads_rd_ff;
      end
      chain_rd_ff <= chain_mem[cand_ff[WINDOW_BITS-1:0]];
   end

   always_comb begin
      level_in     = csr_write_enable ? csr_write_data : level_ff;
      in_op_in     = in_op_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      recv_in      = recv_ff;
      cursor_in    = cursor_ff;
      inserted_in  = inserted_ff;
      pend_len_in  = pend_len_ff;
      pend_dist_in = pend_dist_ff;
      end_seen_in  = end_seen_ff;
      rejected_in  = rejected_ff;
      clr_in       = clr_ff;
      hidx_in      = hidx_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      lazy_in      = lazy_ff;
      chain_lim_in = chain_lim_ff;
      chain_in     = chain_ff;
      dec_len_in   = dec_len_ff;
      dec_dist_in  = dec_dist_ff;
      m2_in        = m2_ff;
      d2_in        = d2_ff;
      hbase_in     = hbase_ff;
      hval_in      = hval_ff;
      hprod_in     = hprod_ff;
      hcnt_in      = hcnt_ff;
      p_in         = p_ff;
      link_in      = link_ff;
      cand_in      = cand_ff;
      maxlen_in    = maxlen_ff;
      best_in      = best_ff;
      l_in         = l_ff;
      bdist_in     = bdist_ff;
      tok_match_in = tok_match_ff;
      tok_lit_in   = tok_lit_ff;
      tok_len_in   = tok_len_ff;
      tok_dist_in  = tok_dist_ff;
      tok_end_in   = tok_end_ff;
      tok_ovf_in   = tok_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_match_in = rsp_match_ff;
      rsp_lit_in   = rsp_lit_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (cmd.op)
         lzhcmf_pkg::OP_CLEAR: begin
            clr_in = clr_ff + HASH_TABLE_BITS'(1);
         end
         lzhcmf_pkg::OP_ACCEPT: begin
            in_op_in   = req_op;
            in_byte_in = req_data_byte;
            in_last_in = req_last;
         end
         lzhcmf_pkg::OP_EVAL: begin
            case (ev)
               lzhcmf_pkg::EV_OVF: begin
                  rejected_in  = 1'b1;
                  tok_match_in = 1'b0;
                  tok_lit_in   = '0;
                  tok_len_in   = '0;
                  tok_dist_in  = '0;
                  tok_end_in   = 1'b0;
                  tok_ovf_in   = 1'b1;
               end
               lzhcmf_pkg::EV_WRITE: begin
                  recv_in     = recv_ff + PW'(1);
                  end_seen_in = end_seen_ff | in_last_ff;
               end
               lzhcmf_pkg::EV_END: begin
                  tok_match_in = 1'b0;
                  tok_lit_in   = '0;
                  tok_len_in   = '0;
                  tok_dist_in  = '0;
                  tok_end_in   = 1'b1;
                  tok_ovf_in   = 1'b0;
               end
               default: begin
               end
            endcase
         end
         lzhcmf_pkg::OP_DEC_INIT: begin
            pos_in       = cursor_ff;
            phase_in     = 1'b0;
            chain_lim_in = lzhcmf_pkg::chain_limit(level_ff);
            lazy_in      = (level_ff > lzhcmf_pkg::LEVEL_W'(1));
            dec_len_in   = pend_len_ff;
            dec_dist_in  = pend_dist_ff;
            pend_len_in  = '0;
            pend_dist_in = '0;
         end
         lzhcmf_pkg::OP_INS_SKIP: begin
            inserted_in = inserted_ff + PW'(1);
         end
         lzhcmf_pkg::OP_INS_BEGIN: begin
            hbase_in = inserted_ff;
            hcnt_in  = '0;
         end
         lzhcmf_pkg::OP_HASH_STEP: begin
            case (hcnt_ff)
               3'd1:    hval_in[7:0]   = hist_rda_ff;
               3'd2:    hval_in[15:8]  = hist_rda_ff;
               3'd3:    hval_in[23:16] = hist_rda_ff;
               3'd4:    hval_in[31:24] = hist_rda_ff;
               default: hval_in        = hval_ff;
            endcase
            hcnt_in = hcnt_ff + 3'd1;
         end
         lzhcmf_pkg::OP_HASH_MUL: begin
            hprod_in = hval_ff * lzhcmf_pkg::HASH_MUL;
         end
         lzhcmf_pkg::OP_HEAD_RD: begin
            hidx_in = hprod_ff[PW-1 -: HASH_TABLE_BITS];
         end
         lzhcmf_pkg::OP_INSERT: begin
            inserted_in = inserted_ff + PW'(1);
         end
         lzhcmf_pkg::OP_FIND_INIT: begin
            p_in      = tgt;
            hbase_in  = tgt;
            hcnt_in   = '0;
            best_in   = '0;
            bdist_in  = '0;
            chain_in  = chain_lim_ff;
            maxlen_in = (end_seen_ff && rem < PW'(lzhcmf_pkg::MAX_LEN))
                        ? rem[LW-1:0] : lzhcmf_pkg::MAX_LEN;
         end
         lzhcmf_pkg::OP_LOAD_HEAD: begin
            link_in = heads_rd_ff;
         end
         lzhcmf_pkg::OP_TAKE_CAND: begin
            cand_in  = cand_c;
            chain_in = chain_ff - CW'(1);
            l_in     = '0;
         end
         lzhcmf_pkg::OP_L_INC: begin
            l_in = l_ff + LW'(1);
         end
         lzhcmf_pkg::OP_CMP_END: begin
            if (l_ff > best_ff) begin
               best_in  = l_ff;
               bdist_in = find_res_dist[DW-1:0];
            end
         end
         lzhcmf_pkg::OP_LOAD_LINK: begin
            link_in = chain_rd_ff;
         end
         lzhcmf_pkg::OP_FIND_DONE: begin
            if (phase_ff) begin
               m2_in = find_res;
               d2_in = bdist_ff;
            end else begin
               dec_len_in  = find_res;
               dec_dist_in = bdist_ff;
            end
         end
         lzhcmf_pkg::OP_LAZY_BEGIN: begin
            phase_in = 1'b1;
         end
         lzhcmf_pkg::OP_LAZY_KEEP: begin
            pend_len_in  = m2_ff;
            pend_dist_in = d2_ff;
            cursor_in    = pos_ff + PW'(1);
         end
         lzhcmf_pkg::OP_TOK_MATCH: begin
            tok_match_in = 1'b1;
            tok_lit_in   = '0;
            tok_len_in   = dec_len_ff;
            tok_dist_in  = dec_dist_ff;
            tok_end_in   = 1'b0;
            tok_ovf_in   = 1'b0;
            cursor_in    = pos_ff + PW'(dec_len_ff);
         end
         lzhcmf_pkg::OP_LIT_RD: begin
            cursor_in = pos_ff + PW'(1);
         end
         lzhcmf_pkg::OP_TOK_LIT: begin
            tok_match_in = 1'b0;
            tok_lit_in   = hist_rda_ff;
            tok_len_in   = '0;
            tok_dist_in  = '0;
            tok_end_in   = 1'b0;
            tok_ovf_in   = 1'b0;
         end
         lzhcmf_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_match_in = tok_match_ff;
            rsp_lit_in   = tok_lit_ff;
            rsp_len_in   = tok_len_ff;
            rsp_dist_in  = tok_dist_ff;
            rsp_end_in   = tok_end_ff;
            rsp_ovf_in   = tok_ovf_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= lzhcmf_pkg::LEVEL_RESET;
         recv_ff      <= '0;
         cursor_ff    <= '0;
         inserted_ff  <= '0;
         pend_len_ff  <= '0;
         pend_dist_ff <= '0;
         end_seen_ff  <= 1'b0;
         rejected_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         recv_ff      <= recv_in;
         cursor_ff    <= cursor_in;
         inserted_ff  <= inserted_in;
         pend_len_ff  <= pend_len_in;
         pend_dist_ff <= pend_dist_in;
         end_seen_ff  <= end_seen_in;
         rejected_ff  <= rejected_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff     <= in_op_in;
      in_byte_ff   <= in_byte_in;
      in_last_ff   <= in_last_in;
      hidx_ff      <= hidx_in;
      pos_ff       <= pos_in;
      phase_ff     <= phase_in;
      lazy_ff      <= lazy_in;
      chain_lim_ff <= chain_lim_in;
      chain_ff     <= chain_in;
      dec_len_ff   <= dec_len_in;
      dec_dist_ff  <= dec_dist_in;
      m2_ff        <= m2_in;
      d2_ff        <= d2_in;
      hbase_ff     <= hbase_in;
      hval_ff      <= hval_in;
      hprod_ff     <= hprod_in;
      hcnt_ff      <= hcnt_in;
      p_ff         <= p_in;
      link_ff      <= link_in;
      cand_ff      <= cand_in;
      maxlen_ff    <= maxlen_in;
      best_ff      <= best_in;
      l_ff         <= l_in;
      bdist_ff     <= bdist_in;
      tok_match_ff <= tok_match_in;
      tok_lit_ff   <= tok_lit_in;
      tok_len_ff   <= tok_len_in;
      tok_dist_ff  <= tok_dist_in;
      tok_end_ff   <= tok_end_in;
      tok_ovf_ff   <= tok_ovf_in;
      rsp_match_ff <= rsp_match_in;
      rsp_lit_ff   <= rsp_lit_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_match       = rsp_match_ff;
   assign rsp_literal        = rsp_lit_ff;
   assign rsp_match_length   = rsp_len_ff;
   assign rsp_match_distance = rsp_dist_ff;
   assign rsp_stream_end     = rsp_end_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule
`default_nettype wire

// ===== hdl/lz77_hash_chain_match_finder.sv =====
// Top level of the LZ77 hash-chain match finder with lazy matching.
// Usage: the req channel carries one beat per stream byte (req_op = 0) or per drain step
// (req_op = 1); req_last marks the final byte. The rsp channel returns at most one token
// beat per request beat: a literal, a match (length 4 to 258, distance 1 to the window),
// an end marker once all tokens are out, or an overflow beat once the stream passed 2^31
// bytes. csr_write_data sets the compression level on a cycle with csr_write_enable high.
// A decision hashes each newly inserted position (four history bytes, a multiply, a head
// read and an insert), then walks the hash chain, comparing candidates byte by byte,
// over up to 32, 128 or 512 candidates, twice with lazy matching. The single history
// read port pair and this chain walk set the rate.
// After reset the hash head table is cleared, one entry per cycle, through all
// 2^HASH_TABLE_BITS entries, during which req_ready stays low.
// A finished token waits in the output register; when the receiver stalls, the next
// request beat is still taken and processed up to its own token, which then waits.
`default_nettype none
module lz77_hash_chain_match_finder #(
   parameter int WINDOW_BITS     = lzhcmf_pkg::WINDOW_BITS_DEF,
   parameter int HASH_TABLE_BITS = lzhcmf_pkg::HASH_TABLE_BITS_DEF,
   parameter int BUFFER_BITS     = lzhcmf_pkg::BUFFER_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [lzhcmf_pkg::LEVEL_W-1:0] csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_op,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_is_match,
   output logic [7:0]                          rsp_literal,
   output logic [lzhcmf_pkg::LEN_W-1:0]        rsp_match_length,
   output logic [lzhcmf_pkg::DIST_W-1:0]       rsp_match_distance,
   output logic                                rsp_stream_end,
   output logic                                rsp_overflow
);

   lzhcmf_pkg::dp_cmd_type    cmd;
   lzhcmf_pkg::dp_status_type status;

   lzhcmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lzhcmf_dp #(
      .WINDOW_BITS     (WINDOW_BITS),
      .HASH_TABLE_BITS (HASH_TABLE_BITS),
      .BUFFER_BITS     (BUFFER_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_last           (req_last),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_is_match       (rsp_is_match),
      .rsp_literal        (rsp_literal),
      .rsp_match_length   (rsp_match_length),
      .rsp_match_distance (rsp_match_distance),
      .rsp_stream_end     (rsp_stream_end),
      .rsp_overflow       (rsp_overflow),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
`default_nettype wire

// ===== hdl/lzhcmf_checker.sv =====
// Port-level checks of the match finder and their binding to the top level.
`default_nettype none
module lzhcmf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_is_match,
   input wire logic [7:0]                     rsp_literal,
   input wire logic [lzhcmf_pkg::LEN_W-1:0]   rsp_match_length,
   input wire logic [lzhcmf_pkg::DIST_W-1:0]  rsp_match_distance,
   input wire logic                           rsp_stream_end,
   input wire logic                           rsp_overflow
);

   a_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_match |-> rsp_match_length >= lzhcmf_pkg::MIN_LEN
      && rsp_match_length <= lzhcmf_pkg::MAX_LEN && rsp_match_distance != '0
      && rsp_literal == '0 && !rsp_stream_end && !rsp_overflow)
      else $error("match beat with bad fields");

   a_non_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_match |-> rsp_match_length == '0 && rsp_match_distance == '0)
      else $error("non-match beat carries length or distance");

   a_marker_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_stream_end || rsp_overflow) |-> rsp_literal == '0
      && !(rsp_stream_end && rsp_overflow))
      else $error("marker beat carries a literal");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_literal)
      && $stable(rsp_match_length) && $stable(rsp_match_distance))
      else $error("stalled response beat changed");

endmodule

bind lz77_hash_chain_match_finder lzhcmf_checker u_checker (.*);
`default_nettype wire
